// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL; clk and rst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RGES_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rges assertion failed");

// Condition must never be seen outside reset.
`define RGES_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rges illegal condition");

`endif

// ===== design/rges_pkg.sv =====
package rges_pkg;

  localparam int RGES_MAX_WIDTH  = 256;
  localparam int RGES_MAX_HEIGHT = 256;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SOURCE_MODE    = 3'd0,
    CFG_STEP_GAIN      = 3'd1,
    CFG_CORNER_VOLTAGE = 3'd2,
    CFG_CORNER_DRIVE   = 3'd3,
    CFG_GRID_WIDTH     = 3'd4,
    CFG_GRID_HEIGHT    = 3'd5
  } rges_cfg_idx_t;

  // Corner rule codes
  localparam logic MODE_VOLTAGE = 1'b0;
  localparam logic MODE_CURRENT = 1'b1;

  // Classification of one queued beat
  typedef struct packed {
    logic wr;      // sample: update line stores
    logic emit;    // produces a result
    logic corner;
    logic le;
    logic re;
    logic te;
    logic be;
    logic last;
  } rges_flags_t;

  // Arithmetic settings used by the back end
  typedef struct packed {
    logic               source_mode;
    logic [15:0]        step_gain;
    logic signed [31:0] corner_voltage;
    logic signed [31:0] corner_drive;
  } rges_cfg_t;

endpackage

// ===== design/rges_fifo.sv =====
module rges_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

// ===== design/rges_front.sv =====
module rges_front import rges_pkg::*; #(
  parameter int CW = 8,
  parameter int WW = 9,
  parameter int RW = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic signed [31:0] in_node_value,
  input  logic [WW-1:0]      w_eff,
  input  logic [RW-1:0]      h_eff,
  input  logic               full,
  output logic               push,
  output rges_flags_t        push_flags,
  output logic [CW-1:0]      push_col,
  output logic [7:0]         push_row,
  output logic [31:0]        push_val
);

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          done_r;

  logic          acc, drop, row_ge1, re, has_lower;
  logic [RW-1:0] oy;

  assign in_ready = !full;
  assign acc      = in_valid && !full;

  // Classify the beat against the current raster position
  always_comb begin
    drop      = in_req_type ? !done_r : done_r;
    row_ge1   = row_r != '0;
    oy        = row_ge1 ? row_r - RW'(1) : '0;
    re        = (WW'(col_r) + WW'(1)) >= w_eff;
    has_lower = !in_req_type && ((oy + RW'(1)) < h_eff);
    push_flags.wr     = !in_req_type;
    push_flags.emit   = in_req_type || row_ge1;
    push_flags.le     = col_r == '0;
    push_flags.re     = re;
    push_flags.te     = oy == '0;
    push_flags.be     = !has_lower;
    push_flags.corner = (push_flags.le || re) && (push_flags.te || !has_lower);
    push_flags.last   = re && done_r;
  end

  assign push     = acc && !drop;
  assign push_col = col_r;
  assign push_row = 8'(oy);
  assign push_val = in_node_value;

  // Raster position and flush phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      done_r <= 1'b0;
    end else if (push) begin
      if (re) begin
        col_r <= '0;
        if (!done_r) begin
          row_r <= row_r + RW'(1);
          if ((row_r + RW'(1)) >= h_eff) done_r <= 1'b1;
        end else begin
          row_r  <= '0;
          done_r <= 1'b0;
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

endmodule

// ===== design/rges_back.sv =====
module rges_back import rges_pkg::*; #(
  parameter int CW = 8,
  parameter int MAX_WIDTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rges_cfg_t          cfg,
  input  logic               empty,
  output logic               pop,
  input  rges_flags_t        q_flags,
  input  logic [CW-1:0]      q_col,
  input  logic [7:0]         q_row,
  input  logic signed [31:0] q_val,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_new_value,
  output logic [7:0]         out_col,
  output logic [7:0]         out_row,
  output logic               out_frame_last
);

  logic signed [31:0] mid_mem [MAX_WIDTH];
  logic signed [31:0] upr_mem [MAX_WIDTH];

  logic en;

  // Stage B: store read data
  logic               vb_r;
  rges_flags_t        fb_r;
  logic [CW-1:0]      colb_r;
  logic [7:0]         rowb_r;
  logic signed [31:0] vb_val_r, ctrb_r, rgtb_r, upb_r, left_r;
  // Stage C: Laplacian
  logic               vc_r, emitc_r, cornc_r, lastc_r;
  logic [7:0]         colc_r, rowc_r;
  logic signed [31:0] ctrc_r;
  logic signed [35:0] lapc_r;
  // Stage D: product
  logic               vd_r, emitd_r, cornd_r, lastd_r;
  logic [7:0]         cold_r, rowd_r;
  logic signed [31:0] ctrd_r;
  logic signed [52:0] prodd_r;
  // Output register
  logic               out_vld_r, last_r;
  logic [7:0]         col_r, row_r;
  logic [31:0]        val_r;

  logic signed [35:0] sum, lap_nxt;
  logic [2:0]         k;
  logic signed [52:0] rnd_full;
  logic signed [37:0] res;
  logic [31:0]        val_nxt;

  assign en  = !out_vld_r || out_ready;
  assign pop = en && !empty;

  // Line stores: read-first, both middle ports and upper port registered
  always_ff @(posedge clk) begin
    if (en) begin
      ctrb_r <= mid_mem[q_col];
      rgtb_r <= mid_mem[q_col + CW'(1)];
      upb_r  <= upr_mem[q_col];
    end
    if (pop && q_flags.wr) mid_mem[q_col] <= q_val;
    if (en && vb_r && fb_r.wr) upr_mem[colb_r] <= ctrb_r;
  end

  // Five-point Laplacian with edge-aware neighbour count; corners take the corner drive instead
  always_comb begin
    sum = '0;
    k   = 3'd0;
    if (!fb_r.le) begin sum = sum + 36'(left_r);   k = k + 3'd1; end
    if (!fb_r.re) begin sum = sum + 36'(rgtb_r);   k = k + 3'd1; end
    if (!fb_r.te) begin sum = sum + 36'(upb_r);    k = k + 3'd1; end
    if (!fb_r.be) begin sum = sum + 36'(vb_val_r); k = k + 3'd1; end
    if (fb_r.corner) begin
      lap_nxt = 36'(cfg.corner_drive);
    end else begin
      lap_nxt = sum - $signed({1'b0, k}) * 36'(ctrb_r);
    end
  end

  // Round to nearest (ties up), add centre, saturate; voltage-mode corners take the corner voltage
  always_comb begin
    rnd_full = (prodd_r + 53'sd32768) >>> 16;
    res      = 38'(ctrd_r) + 38'($signed(rnd_full[36:0]));
    if (cornd_r && cfg.source_mode == MODE_VOLTAGE) begin
      val_nxt = cfg.corner_voltage;
    end else if (res > 38'sd2147483647) begin
      val_nxt = 32'h7FFF_FFFF;
    end else if (res < -38'sd2147483648) begin
      val_nxt = 32'h8000_0000;
    end else begin
      val_nxt = res[31:0];
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      fb_r     <= q_flags;
      colb_r   <= q_col;
      rowb_r   <= q_row;
      vb_val_r <= q_val;

      emitc_r <= fb_r.emit;
      cornc_r <= fb_r.corner;
      lastc_r <= fb_r.last;
      colc_r  <= 8'(colb_r);
      rowc_r  <= rowb_r;
      ctrc_r  <= ctrb_r;
      lapc_r  <= lap_nxt;

      emitd_r <= emitc_r;
      cornd_r <= cornc_r;
      lastd_r <= lastc_r;
      cold_r  <= colc_r;
      rowd_r  <= rowc_r;
      ctrd_r  <= ctrc_r;
      prodd_r <= $signed({1'b0, cfg.step_gain}) * lapc_r;

      val_r  <= val_nxt;
      col_r  <= cold_r;
      row_r  <= rowd_r;
      last_r <= lastd_r;
    end
  end

  // Stage valids and the left window tap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r      <= 1'b0;
      vc_r      <= 1'b0;
      vd_r      <= 1'b0;
      out_vld_r <= 1'b0;
      left_r    <= '0;
    end else if (en) begin
      vb_r      <= !empty;
      vc_r      <= vb_r;
      vd_r      <= vc_r;
      out_vld_r <= vd_r && emitd_r;
      if (vb_r) left_r <= ctrb_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_new_value  = val_r;
  assign out_col        = col_r;
  assign out_row        = row_r;
  assign out_frame_last = last_r;

endmodule

// ===== design/rc_grid_euler_stencil.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_req_type, in_node_value
// out     | output    | out_valid / out_ready | out_new_value, out_col, out_row,
//         |           |                       | out_frame_last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while the queue has room and out_ready does not hold the back pipeline.
// A result passes in order through the queue, store read, Laplacian, multiply and round stages.
// Reset (rst_n low, synchronous) clears position, queue and stage valids.
// A two-entry queue decouples intake from the stencil pipeline; the whole
// back pipeline holds while a result waits on out_ready.
module rc_grid_euler_stencil import rges_pkg::*; #(
  parameter int MAX_WIDTH  = RGES_MAX_WIDTH,
  parameter int MAX_HEIGHT = RGES_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_node_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_new_value,
  output logic [7:0]  out_col,
  output logic [7:0]  out_row,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = $bits(rges_flags_t) + CW + 8 + 32;

  rges_cfg_t      cfg_r;
  logic [8:0]     grid_width_r, grid_height_r;
  logic [WW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;

  logic           full, empty, push, pop;
  rges_flags_t    push_flags, q_flags;
  logic [CW-1:0]  push_col, q_col;
  logic [7:0]     push_row, q_row;
  logic [31:0]    push_val, q_val;
  logic [DW-1:0]  q_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_mode    <= MODE_VOLTAGE;
      cfg_r.step_gain      <= 16'd16384;
      cfg_r.corner_voltage <= '0;
      cfg_r.corner_drive   <= '0;
      grid_width_r         <= 9'd256;
      grid_height_r        <= 9'd256;
    end else if (cfg_valid) begin
      unique case (rges_cfg_idx_t'(cfg_index))
        CFG_SOURCE_MODE:    cfg_r.source_mode    <= cfg_data[0];
        CFG_STEP_GAIN:      cfg_r.step_gain      <= cfg_data[15:0];
        CFG_CORNER_VOLTAGE: cfg_r.corner_voltage <= cfg_data;
        CFG_CORNER_DRIVE:   cfg_r.corner_drive   <= cfg_data;
        CFG_GRID_WIDTH:     grid_width_r         <= cfg_data[8:0];
        CFG_GRID_HEIGHT:    grid_height_r        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Grid size clamped to [3, max]
  always_comb begin
    if (grid_width_r < 9'd3)                       w_eff = WW'(3);
    else if (32'(grid_width_r) > 32'(MAX_WIDTH))   w_eff = WW'(MAX_WIDTH);
    else                                           w_eff = WW'(grid_width_r);
    if (grid_height_r < 9'd3)                      h_eff = RW'(3);
    else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
    else                                           h_eff = RW'(grid_height_r);
  end

  rges_front #(.CW(CW), .WW(WW), .RW(RW)) u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type,
    .in_node_value (in_node_value),
    .w_eff, .h_eff, .full,
    .push, .push_flags, .push_col, .push_row, .push_val
  );

  rges_fifo #(.DW(DW)) u_fifo (
    .clk, .rst_n,
    .push,
    .push_data ({push_flags, push_col, push_row, push_val}),
    .full,
    .pop,
    .pop_data  (q_data),
    .empty
  );

  assign {q_flags, q_col, q_row, q_val} = q_data;

  rges_back #(.CW(CW), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk, .rst_n,
    .cfg     (cfg_r),
    .empty, .pop,
    .q_flags, .q_col, .q_row,
    .q_val   (q_val),
    .out_valid, .out_ready, .out_new_value, .out_col, .out_row, .out_frame_last
  );

  // Queue is never written when it has no room
  `RGES_NEVER(a_no_overflow, push && full)
  // Frame end falls on the right edge of the grid
  `RGES_ASSERT(a_last_on_edge, out_valid && out_frame_last |-> out_col == 8'(w_eff - WW'(1)))
  // Front never pushes while the queue reports full through in_ready
  `RGES_ASSERT(a_ready_tracks_queue, push |-> in_ready)

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import rges_pkg::*;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;
  localparam int   LONG_HOLD  = 300;
  localparam int   DRAIN_GAP  = 12;

  // One expected node update
  typedef struct {
    logic [31:0] new_value;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        frame_last;
  } node_update_t;

  // Explicit Euler grid predictor plus expected update store
  class euler_grid_board;
    bit          src_mode;
    bit [15:0]   gain;
    int          v_corner;
    int          i_drive;
    bit [8:0]    width_reg;
    bit [8:0]    height_reg;
    int          row_up[256];
    int          row_mid[256];
    int          win[3];
    int unsigned pos_col;
    int unsigned pos_row;
    bit          flushing;
    node_update_t pending_q[$];
    int          mismatches;

    function new();
      src_mode   = MODE_VOLTAGE;
      gain       = 16'd16384;
      v_corner   = 0;
      i_drive    = 0;
      width_reg  = 9'd256;
      height_reg = 9'd256;
      foreach (row_up[i]) begin
        row_up[i]  = 0;
        row_mid[i] = 0;
      end
      win        = '{0, 0, 0};
      pos_col    = 0;
      pos_row    = 0;
      flushing   = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(bit [8:0] v);
      if (v < 3) return 3;
      if (v > 256) return 256;
      return v;
    endfunction

    function void write_reg(rges_cfg_idx_t idx, logic [31:0] d);
      case (idx)
        CFG_SOURCE_MODE:    src_mode = d[0];
        CFG_STEP_GAIN:      gain = d[15:0];
        CFG_CORNER_VOLTAGE: v_corner = d;
        CFG_CORNER_DRIVE:   i_drive = d;
        CFG_GRID_WIDTH:     width_reg = d[8:0];
        CFG_GRID_HEIGHT:    height_reg = d[8:0];
        default: ;
      endcase
    endfunction

    // Accepted input beat: advance stencil state, queue update if one is due
    function void note_beat(logic req, logic [31:0] v_in);
      int unsigned w, h, c, oy;
      bit was_flush, emit, has_lower, last, le, re, te, be;
      int v, left, ctr, right, up;
      longint sum, k, lap, res;
      node_update_t u;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      c = pos_col;
      was_flush = flushing;
      v = v_in;
      last = 0;
      if (req == REQ_SAMPLE && was_flush) return;
      if (req == REQ_FLUSH && !was_flush) return;
      left  = win[1];
      ctr   = row_mid[c];
      right = (c + 1 < 256) ? row_mid[c + 1] : 0;
      up    = row_up[c];
      win   = '{left, ctr, right};
      if (req == REQ_SAMPLE) begin
        emit = pos_row >= 1;
        oy = emit ? pos_row - 1 : 0;
        has_lower = oy + 1 < h;
        row_up[c]  = ctr;
        row_mid[c] = v;
      end else begin
        emit = 1;
        oy = pos_row >= 1 ? pos_row - 1 : 0;
        has_lower = 0;
      end
      // position advance
      if (c + 1 >= w) begin
        pos_col = 0;
        if (!was_flush) begin
          pos_row++;
          if (pos_row >= h) flushing = 1;
        end else begin
          pos_row  = 0;
          flushing = 0;
          last     = 1;
        end
      end else begin
        pos_col = c + 1;
      end
      if (!emit) return;
      le = c == 0;
      re = c + 1 >= w;
      te = oy == 0;
      be = !has_lower;
      if ((le || re) && (te || be)) begin
        if (src_mode == MODE_VOLTAGE) res = v_corner;
        else res = longint'(ctr) + ((longint'(gain) * longint'(i_drive) + 32768) >>> 16);
      end else begin
        sum = 0;
        k = 0;
        if (!le) begin sum += left;  k++; end
        if (!re) begin sum += right; k++; end
        if (!te) begin sum += up;    k++; end
        if (!be) begin sum += v;     k++; end
        lap = sum - k * longint'(ctr);
        res = longint'(ctr) + ((longint'(gain) * lap + 32768) >>> 16);
      end
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      u.new_value  = res[31:0];
      u.col        = c[7:0];
      u.row        = oy[7:0];
      u.frame_last = last;
      pending_q.push_back(u);
    endfunction

    function void check_beat(logic [31:0] nv, logic [7:0] col, logic [7:0] row, logic fl);
      node_update_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected update: value %h col %0d row %0d last %0b", nv, col, row, fl);
        return;
      end
      e = pending_q.pop_front();
      if (nv !== e.new_value || col !== e.col || row !== e.row || fl !== e.frame_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("update mismatch: exp %h/%0d/%0d/%0b got %h/%0d/%0d/%0b",
                   e.new_value, e.col, e.row, e.frame_last, nv, col, row, fl);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = REQ_SAMPLE;
  logic [31:0] in_node_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_new_value;
  logic [7:0]  out_col;
  logic [7:0]  out_row;
  logic        out_frame_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_SOURCE_MODE;
  logic [31:0] cfg_data = '0;

  euler_grid_board board = new();
  bit jitter = 1'b1;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sent_nodes = 0;

  // Directed 3x3 node values: extremes and sign flips
  logic [31:0] pick_vals[9] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF};

  rc_grid_euler_stencil u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_node_value(in_node_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_new_value(out_new_value), .out_col(out_col), .out_row(out_row),
    .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check beats, random backpressure, long hold on request
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_beat(out_new_value, out_col, out_row, out_frame_last);
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !jitter || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_beat(logic req, logic [31:0] v);
    int gap;
    gap = (jitter && $urandom_range(99) < 38) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_node_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_beat(req, v);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    stop_input();
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(rges_cfg_idx_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, d);
  endtask

  function automatic logic [31:0] node_pick();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 4000)) - 32'd2000;
      3: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // One raster frame then the flush row; optional stray beats on the way
  task automatic run_frame(bit noise);
    int unsigned w, h;
    w = board.clamp_dim(board.width_reg);
    h = board.clamp_dim(board.height_reg);
    if (noise) send_beat(REQ_FLUSH, $urandom);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        send_beat(REQ_SAMPLE, node_pick());
        sent_nodes++;
      end
    for (int c = 0; c < w; c++) begin
      if (noise && $urandom_range(3) == 0) send_beat(REQ_SAMPLE, $urandom);
      send_beat(REQ_FLUSH, $urandom);
    end
  endtask

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x3 grids, extreme values, both corner rules
    write_reg(CFG_GRID_WIDTH, 32'd3);
    write_reg(CFG_GRID_HEIGHT, 32'd3);
    write_reg(CFG_STEP_GAIN, 32'hFFFF);
    write_reg(CFG_CORNER_VOLTAGE, 32'h7FFF_FFFF);
    write_reg(CFG_CORNER_DRIVE, 32'h8000_0000);
    write_reg(CFG_SOURCE_MODE, MODE_VOLTAGE);
    send_beat(REQ_FLUSH, 32'hFFFF_FFFF);
    foreach (pick_vals[i]) send_beat(REQ_SAMPLE, pick_vals[i]);
    send_beat(REQ_SAMPLE, 32'h1234_5678);
    repeat (3) send_beat(REQ_FLUSH, 32'h0);
    drain();
    write_reg(CFG_SOURCE_MODE, MODE_CURRENT);
    write_reg(CFG_CORNER_DRIVE, 32'h7FFF_FFFF);
    write_reg(CFG_STEP_GAIN, 32'h0);
    foreach (pick_vals[i]) send_beat(REQ_SAMPLE, ~pick_vals[i]);
    repeat (3) send_beat(REQ_FLUSH, 32'h0);
    drain();

    // Tallest column: width zero clamps to three, height above range clamps,
    // no idling, long receiver hold at the start
    write_reg(CFG_STEP_GAIN, 32'h8000);
    jitter = 1'b0;
    write_reg(CFG_GRID_WIDTH, 32'd0);
    write_reg(CFG_GRID_HEIGHT, 32'd511);
    hold_seq++;
    run_frame(1'b1);
    drain();
    jitter = 1'b1;

    // Random frames, small, reconfigured between frames
    sent_nodes = 0;
    while (sent_nodes < 120) begin
      pick = $urandom_range(3);
      write_reg(CFG_GRID_WIDTH, (pick == 0) ? $urandom_range(0, 12) : $urandom_range(3, 12));
      write_reg(CFG_GRID_HEIGHT, (pick == 1) ? $urandom_range(0, 10) : $urandom_range(3, 8));
      if ($urandom_range(1)) write_reg(CFG_SOURCE_MODE, $urandom);
      if ($urandom_range(1))
        write_reg(CFG_STEP_GAIN, ($urandom_range(3) == 0) ? 32'hFFFF : $urandom);
      if ($urandom_range(1)) write_reg(CFG_CORNER_VOLTAGE, $urandom);
      if ($urandom_range(1)) write_reg(CFG_CORNER_DRIVE, node_pick());
      jitter = $urandom_range(5) != 0;
      run_frame($urandom_range(4) == 0);
      drain();
    end
    jitter = 1'b1;

    stop_input();
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
